@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the allocator checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

@@ rtl/core/ffa_pkg.sv @@
// Package for the first-fit allocator: sizes, codes and state type.
// No dependencies.
`default_nettype none
package ffa_pkg;
   localparam int HeapBytes = 4096;
   localparam int NodeBytes = 16;
   localparam int HeaderBytes = 16;
   localparam int GranuleBytes = 8;
   localparam int HeapWords = HeapBytes / 8;
   localparam int WordAw = $clog2(HeapWords);
   localparam int MaxWalk = HeapBytes / NodeBytes;
   localparam int StepW = $clog2(MaxWalk + 1);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;
   localparam logic [1:0] REG_MAGIC = 2'd0;

   typedef enum logic [4:0] {
      S_IDLE, S_INIT, S_RD_A, S_WT_A, S_CHK_A, S_WT_B, S_GOT_B,
      S_SPLIT_A, S_SPLIT_B, S_LINK, S_HDR_A, S_HDR_B,
      S_F_RD, S_F_WT, S_F_CHK, S_F_OLD, S_F_OWT, S_F_OCHK, S_F_WA, S_F_WB,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

@@ rtl/core/ffa_heap_ram.sv @@
// Word memory of the heap, one port, read data registered twice.
// Depends on ffa_pkg.
`default_nettype none
module ffa_heap_ram (
   input  wire logic                clock,
   input  wire logic                we,
   input  wire logic [ffa_pkg::WordAw-1:0] addr,
   input  wire logic [63:0]         wdata,
   output logic [63:0]              rdata
);
   import ffa_pkg::*;
   logic [63:0] mem [HeapWords];
   logic [63:0] rdata_q;
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_q <= mem[addr];
      rdata <= rdata_q;
   end
endmodule
`default_nettype wire

@@ rtl/core/first_fit_free_list_allocator.sv @@
// A first-fit allocator over a 4096-byte heap held in a 512-word memory with a single port and
// read data registered twice. One request is taken at a time; req_tready is low while it runs
// and while a result waits. Allocate walks the free list, reading the size and then the link
// of each node, until a node fits or the walk ends; on a fit it writes a remainder node when
// room is left, relinks the list and writes the block header. Query walks the list, summing sizes
// and counting nodes. Free checks the magic word of the header, reads the old head, merges with
// it when adjacent and writes the freed node as the new head. After reset the initial node is
// written before the first request is taken. The result stays in an output register until taken.
`default_nettype none
module first_fit_free_list_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[1:0], request_bytes[14:2], free_address[26:15]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], address[13:2], free_bytes[26:14], free_nodes[35:27]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import ffa_pkg::*;
   state_type state_ff, state_in;
   logic [31:0] magic_ff;
   logic [1:0] op_ff, op_in;
   logic [13:0] need_ff, need_in;
   logic [11:0] fa_ff, fa_in;
   logic [12:0] cur_ff, cur_in, prev_ff, prev_in, head_ff, head_in, link_ff, link_in;
   logic have_prev_ff, have_prev_in;
   logic [63:0] sz_ff, sz_in;
   logic [StepW-1:0] steps_ff, steps_in;
   logic [12:0] sum_ff, sum_in;
   logic [8:0] cnt_ff, cnt_in;
   logic [1:0] st_ff, st_in;
   logic [11:0] addr_ff, addr_in;
   logic rv_ff, rv_in;
   logic we;
   logic [WordAw-1:0] ra;
   logic [63:0] wd, rd;
   logic [13:0] q;
   logic [12:0] hdr;
   logic [63:0] ns;

   ffa_heap_ram u_ram (.clock(clock), .we(we), .addr(ra), .wdata(wd), .rdata(rd));

   assign csr_pready = 1'b1;
   assign csr_prdata = magic_ff;
   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {4'd0, cnt_ff, sum_ff, addr_ff, st_ff};
   assign q = {1'b0, cur_ff} + 14'(HeaderBytes) + need_ff;
   assign hdr = 13'(fa_ff) - 13'(HeaderBytes);

   function automatic logic [12:0] norm(input logic [63:0] v);
      return (v < 64'(HeapBytes)) ? v[12:0] : 13'(HeapBytes);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         magic_ff <= 32'h01234567;
         head_ff <= '0;
         rv_ff <= 1'b0;
         steps_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         rv_ff <= rv_in;
         steps_ff <= steps_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_MAGIC)
            magic_ff <= csr_pwdata;
      end
      op_ff <= op_in; need_ff <= need_in; fa_ff <= fa_in; cur_ff <= cur_in;
      prev_ff <= prev_in; link_ff <= link_in; have_prev_ff <= have_prev_in; sz_ff <= sz_in;
      sum_ff <= sum_in; cnt_ff <= cnt_in; st_ff <= st_in;
      addr_ff <= addr_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: if (steps_ff[0]) state_in = S_IDLE;
         S_IDLE: if (req_tvalid && req_tready) begin
            if (req_tdata[1:0] == OP_FREE) state_in = S_F_RD;
            else if (req_tdata[1:0] == OP_ALLOC || req_tdata[1:0] == OP_QUERY) state_in = S_RD_A;
            else state_in = S_DONE;
         end
         S_RD_A: begin
            if (cur_ff >= 13'(HeapBytes) || 32'(steps_ff) >= MaxWalk) state_in = S_DONE;
            else state_in = S_WT_A;
         end
         S_WT_A: state_in = S_CHK_A;
         S_CHK_A: state_in = S_WT_B;
         S_WT_B: state_in = S_GOT_B;
         S_GOT_B: begin
            if (op_ff == OP_ALLOC && st_ff == ST_OK)
               state_in = (q < 14'(HeapBytes)) ? S_SPLIT_A : S_LINK;
            else state_in = S_RD_A;
         end
         S_SPLIT_A: state_in = S_SPLIT_B;
         S_SPLIT_B: state_in = S_LINK;
         S_LINK: state_in = S_HDR_A;
         S_HDR_A: state_in = S_HDR_B;
         S_HDR_B: state_in = S_DONE;
         S_F_RD: state_in = (fa_ff < 12'(HeaderBytes) ||
                  {1'b0, hdr} + 14'(NodeBytes) > 14'(HeapBytes)) ? S_DONE : S_F_WT;
         S_F_WT: state_in = S_F_CHK;
         S_F_CHK: state_in = (rd != {32'd0, magic_ff}) ? S_DONE : S_F_OLD;
         S_F_OLD: state_in = S_F_OWT;
         S_F_OWT: state_in = S_F_OCHK;
         S_F_OCHK: state_in = S_F_WA;
         S_F_WA: state_in = S_F_WB;
         S_F_WB: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op_in = op_ff; need_in = need_ff; fa_in = fa_ff; cur_in = cur_ff; prev_in = prev_ff;
      link_in = link_ff; have_prev_in = have_prev_ff; sz_in = sz_ff; steps_in = steps_ff;
      sum_in = sum_ff; cnt_in = cnt_ff; st_in = st_ff; addr_in = addr_ff;
      head_in = head_ff; rv_in = rv_ff && !rsp_tready;
      we = 1'b0; ra = cur_ff[3+:WordAw]; wd = '0; ns = '0;
      case (state_ff)
         S_INIT: begin
            we = 1'b1;
            ra = steps_ff[0] ? WordAw'(1) : '0;
            wd = steps_ff[0] ? 64'(HeapBytes) : 64'(HeapBytes - NodeBytes);
            steps_in = steps_ff + 1'b1;
         end
         S_IDLE: if (req_tvalid && req_tready) begin
            op_in = req_tdata[1:0];
            need_in = (14'(req_tdata[14:2]) + 14'(GranuleBytes - 1)) &
                      ~14'(GranuleBytes - 1);
            fa_in = req_tdata[26:15];
            cur_in = head_ff; have_prev_in = 1'b0; steps_in = '0;
            sum_in = '0; cnt_in = '0; addr_in = '0;
            st_in = (req_tdata[1:0] == OP_ALLOC) ? ST_NOFIT : ST_OK;
         end
         S_RD_A: ra = cur_ff[3+:WordAw];
         S_WT_A: ra = cur_ff[3+:WordAw] + 1'b1;
         S_CHK_A: begin
            ra = cur_ff[3+:WordAw] + 1'b1;
            sz_in = rd;
            if (op_ff == OP_ALLOC) begin
               if (rd >= 64'(HeaderBytes) + 64'(need_ff)) st_in = ST_OK;
            end else begin
               sum_in = (rd >= 64'd8191 || 64'(sum_ff) + rd >= 64'd8191) ? 13'd8191 :
                        sum_ff + rd[12:0];
               if (cnt_ff != 9'd511) cnt_in = cnt_ff + 1'b1;
            end
         end
         S_GOT_B: begin
            link_in = norm(rd);
            if (!(op_ff == OP_ALLOC && st_ff == ST_OK)) begin
               prev_in = cur_ff; have_prev_in = 1'b1;
               cur_in = rd[12:0] | {13{rd[63:13] != 0}};
               steps_in = steps_ff + 1'b1;
            end
         end
         S_SPLIT_A: begin
            we = 1'b1; ra = q[3+:WordAw];
            wd = sz_ff - 64'(HeaderBytes) - 64'(need_ff);
         end
         S_SPLIT_B: begin
            we = 1'b1; ra = q[3+:WordAw] + 1'b1; wd = 64'(link_ff);
            link_in = q[12:0];
         end
         S_LINK: begin
            if (have_prev_ff) begin
               we = 1'b1; ra = prev_ff[3+:WordAw] + 1'b1; wd = 64'(link_ff);
            end else head_in = link_ff;
         end
         S_HDR_A: begin we = 1'b1; ra = cur_ff[3+:WordAw]; wd = 64'(need_ff); end
         S_HDR_B: begin
            we = 1'b1; ra = cur_ff[3+:WordAw] + 1'b1; wd = {32'd0, magic_ff};
            addr_in = 12'(cur_ff + 13'(HeaderBytes));
         end
         S_F_RD: begin
            ra = hdr[3+:WordAw] + 1'b1;
            st_in = ST_BAD; cur_in = hdr;
         end
         S_F_WT: ra = hdr[3+:WordAw];
         S_F_CHK: ra = head_ff[3+:WordAw];
         S_F_OLD: begin
            ra = head_ff[3+:WordAw] + 1'b1;
            ns = (rd + 64'(HeaderBytes) < 64'(NodeBytes)) ? 64'd0 :
                 rd + 64'(HeaderBytes) - 64'(NodeBytes);
            sz_in = ns;
            link_in = head_ff;
         end
         S_F_OWT: begin
            ra = head_ff[3+:WordAw] + 1'b1;
            if (head_ff < 13'(HeapBytes) &&
                64'(cur_ff) + sz_ff + 64'(NodeBytes) == 64'(head_ff))
               sz_in = sz_ff + rd + 64'(NodeBytes);
            else sz_in = sz_ff;
            have_prev_in = head_ff < 13'(HeapBytes) &&
                64'(cur_ff) + sz_ff + 64'(NodeBytes) == 64'(head_ff);
         end
         S_F_OCHK: if (have_prev_ff) link_in = norm(rd);
         S_F_WA: begin we = 1'b1; ra = cur_ff[3+:WordAw]; wd = sz_ff; end
         S_F_WB: begin
            we = 1'b1; ra = cur_ff[3+:WordAw] + 1'b1; wd = 64'(link_ff);
            head_in = cur_ff; st_in = ST_OK;
         end
         S_DONE: begin
            rv_in = 1'b1;
            if (op_ff != OP_QUERY) begin sum_in = '0; cnt_in = '0; end
            if (op_ff != OP_ALLOC || st_ff != ST_OK) addr_in = '0;
            if (op_ff == OP_NONE) st_in = ST_OK;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/core/ffa_checker.sv @@
// Port checker for the allocator, bound to the top level.
// Depends on assert_macros.svh and first_fit_free_list_allocator.
`default_nettype none
`include "assert_macros.svh"
module ffa_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);
   `ASSERT_IMPLIES(no_accept_while_busy, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_NEXT(rsp_holds, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_IMPLIES(status_legal, clock, reset, rsp_tvalid, rsp_tdata[1:0] != 2'd3)
   `ASSERT_NEXT(busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule
bind first_fit_free_list_allocator ffa_port_checker u_ffa_checker (.*);
`default_nettype wire

@@ test/ffa_checker.sv @@
// Checker for the first-fit allocator: predicts every reply from its own heap image.
// Depends on ffa_pkg for sizes, operation codes and status codes.
`timescale 1ns / 100ps
module ffa_checker
   import ffa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           errors,
   output int           pending,
   output int           replies,
   output int           nofit_seen,
   output int           badfree_seen,
   output logic [511:0] word_written,
   output logic [511:0] live_header
);
   logic [63:0] heap_image [512];
   logic [63:0] list_head;
   logic [31:0] magic_word;
   logic [39:0] reply_queue [$];

   function automatic logic [8:0] word_lo(input logic [63:0] offset);
      return offset[11:3];
   endfunction

   function automatic logic [8:0] word_hi(input logic [63:0] offset);
      return offset[11:3] + 9'd1;
   endfunction

   function automatic void put_word(input logic [8:0] index, input logic [63:0] value);
      heap_image[index] = value;
      word_written[index] = 1'b1;
   endfunction

   function automatic logic [63:0] link_of(input logic [63:0] value);
      return (value < HeapBytes) ? value : 64'(HeapBytes);
   endfunction

   function automatic void allocate(input logic [63:0] wanted, output logic [1:0] status,
                                    output logic [11:0] address);
      logic [63:0] need, cur, prev, size, next, split, link;
      logic        have_prev, found;
      int          steps;
      need = ((wanted + GranuleBytes - 1) / GranuleBytes) * GranuleBytes;
      cur = list_head;
      prev = 0;
      have_prev = 1'b0;
      found = 1'b0;
      steps = 0;
      status = ST_NOFIT;
      address = '0;
      while (cur < HeapBytes && steps < MaxWalk && !found) begin
         if (heap_image[word_lo(cur)] >= HeaderBytes + need) begin
            found = 1'b1;
         end else begin
            prev = cur;
            have_prev = 1'b1;
            cur = heap_image[word_hi(cur)];
            steps++;
         end
      end
      if (found) begin
         size = heap_image[word_lo(cur)];
         next = heap_image[word_hi(cur)];
         split = cur + HeaderBytes + need;
         link = link_of(next);
         if (split < HeapBytes) begin
            put_word(word_lo(split), size - HeaderBytes - need);
            put_word(word_hi(split), link);
            link = split;
         end
         if (have_prev) put_word(word_hi(prev), link);
         else list_head = link;
         put_word(word_lo(cur), need);
         put_word(word_hi(cur), 64'(magic_word));
         live_header[word_lo(cur)] = 1'b1;
         status = ST_OK;
         address = 12'(cur + HeaderBytes);
      end
   endfunction

   function automatic void release_block(input logic [63:0] user_offset,
                                         output logic [1:0] status);
      logic [63:0] hdr, size, node_size, old_head, next;
      status = ST_BAD;
      if (user_offset >= HeaderBytes) begin
         hdr = user_offset - HeaderBytes;
         if (hdr + NodeBytes <= HeapBytes && heap_image[word_hi(hdr)] == 64'(magic_word))
         begin
            size = heap_image[word_lo(hdr)];
            node_size = (size + HeaderBytes < NodeBytes) ? 0 : size + HeaderBytes - NodeBytes;
            old_head = list_head;
            next = old_head;
            if (old_head < HeapBytes && hdr + node_size + NodeBytes == old_head) begin
               node_size += heap_image[word_lo(old_head)] + NodeBytes;
               next = link_of(heap_image[word_hi(old_head)]);
            end
            put_word(word_lo(hdr), node_size);
            put_word(word_hi(hdr), next);
            live_header[word_lo(hdr)] = 1'b0;
            list_head = hdr;
            status = ST_OK;
         end
      end
   endfunction

   function automatic void survey(output logic [12:0] total, output logic [8:0] count);
      logic [63:0] cur, sum, nodes, size;
      int          steps;
      cur = list_head;
      sum = 0;
      nodes = 0;
      steps = 0;
      while (cur < HeapBytes && steps < MaxWalk) begin
         size = heap_image[word_lo(cur)];
         sum = (size >= 8191 || sum + size >= 8191) ? 64'd8191 : sum + size;
         if (nodes < 511) nodes++;
         cur = heap_image[word_hi(cur)];
         steps++;
      end
      total = 13'(sum);
      count = 9'(nodes);
   endfunction

   function automatic logic [39:0] expected_reply(input logic [31:0] item);
      logic [1:0]  status;
      logic [11:0] address;
      logic [12:0] total;
      logic [8:0]  count;
      status = ST_OK;
      address = '0;
      total = '0;
      count = '0;
      case (item[1:0])
         OP_ALLOC: allocate(64'(item[14:2]), status, address);
         OP_FREE: release_block(64'(item[26:15]), status);
         OP_QUERY: survey(total, count);
         default: ;
      endcase
      return {4'b0, count, total, address, status};
   endfunction

   always @(posedge clock) begin
      logic [39:0] want;
      if (reset) begin
         for (int i = 0; i < 512; i++) heap_image[i] = '0;
         word_written = '0;
         live_header = '0;
         put_word(9'd0, 64'(HeapBytes - NodeBytes));
         put_word(9'd1, 64'(HeapBytes));
         list_head = 0;
         magic_word = 32'h0123_4567;
         reply_queue.delete();
         pending = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            replies++;
            if (rsp_tdata[1:0] == ST_NOFIT) nofit_seen++;
            if (rsp_tdata[1:0] == ST_BAD) badfree_seen++;
            if (reply_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected reply %h", rsp_tdata);
            end else begin
               want = reply_queue.pop_front();
               if (want !== rsp_tdata) begin
                  errors++;
                  if (errors <= 10)
                     $display("Mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d (%h)",
                              want[1:0], want[13:2], want[26:14], want[35:27],
                              rsp_tdata[1:0], rsp_tdata[13:2], rsp_tdata[26:14],
                              rsp_tdata[35:27], rsp_tdata[39:36]);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == REG_MAGIC)
            magic_word = csr_pwdata;
         if (req_tvalid && req_tready) reply_queue.push_back(expected_reply(req_tdata));
         pending = reply_queue.size();
      end
   end

   initial begin
      errors = 0;
      pending = 0;
      replies = 0;
      nofit_seen = 0;
      badfree_seen = 0;
      word_written = '0;
      live_header = '0;
   end
endmodule

@@ test/testbench.sv @@
// Top of the allocator testbench: clock, reset, request and register stimulus, verdict.
// Depends on ffa_pkg, the allocator RTL and the ffa_checker module.
`timescale 1ns / 100ps
module testbench;
   import ffa_pkg::*;

   localparam int CycleLimit = 20000000;
   localparam int PhaseItems = 350;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [1:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           errors, pending, replies, nofit_seen, badfree_seen;
   logic [511:0] word_written, live_header;
   logic         hold_request = 1'b0;
   logic         steady = 1'b0;
   logic         safe_bogus = 1'b1;
   int           cycles = 0;
   int           items_sent = 0;

   always #1 clock = ~clock;

   first_fit_free_list_allocator i_dut (.*);

   ffa_checker i_checker (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   // The receiver stalls at random and once holds off for a long stretch.
   initial begin
      logic held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            rsp_tready = steady || ($urandom_range(0, 99) >= 18);
         end
      end
   end

   task automatic send_item(input logic [1:0] op, input logic [12:0] wanted,
                            input logic [11:0] user_offset);
      while (!steady && $urandom_range(0, 99) < 18) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {5'b0, user_offset, wanted, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_magic(input logic [31:0] value);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = REG_MAGIC;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic int live_offset();
      int start;
      start = $urandom_range(0, 511);
      for (int i = 0; i < 512; i++)
         if (live_header[(start + i) % 512]) return ((start + i) % 512) * 8 + HeaderBytes;
      return -1;
   endfunction

   function automatic int stray_offset();
      int g;
      g = $urandom_range(0, 509);
      if (word_written[g] && word_written[g + 1] && !live_header[g])
         return g * 8 + HeaderBytes + $urandom_range(0, 7);
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [12:0] random_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 13'($urandom_range(0, 128));
      if (r < 90) return 13'($urandom_range(0, 1024));
      if (r < 98) return 13'($urandom_range(1025, 4096));
      return 13'($urandom_range(4097, 8191));
   endfunction

   task automatic random_item();
      int r, fa;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         send_item(OP_ALLOC, random_size(), 12'($urandom));
      end else if (r < 85) begin
         fa = live_offset();
         if ($urandom_range(0, 99) < 15 || fa < 0)
            fa = safe_bogus ? stray_offset() : $urandom_range(0, 15);
         send_item(OP_FREE, 13'($urandom), 12'(fa));
      end else if (r < 95) begin
         send_item(OP_QUERY, 13'($urandom), 12'($urandom));
      end else begin
         send_item(OP_NONE, 13'($urandom), 12'($urandom));
      end
   endtask

   task automatic run_phase(input int count);
      repeat (count) random_item();
   endtask

   initial begin
      int fa;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_magic(32'h0123_4567);
      send_item(OP_QUERY, 13'd0, 12'd0);
      send_item(OP_ALLOC, 13'd0, 12'd0);
      send_item(OP_ALLOC, 13'd1, 12'd0);
      send_item(OP_ALLOC, 13'd4096, 12'd0);
      send_item(OP_ALLOC, 13'd8191, 12'd0);
      send_item(OP_ALLOC, 13'd4080, 12'd0);
      send_item(OP_ALLOC, 13'd100, 12'd0);
      send_item(OP_QUERY, 13'h1fff, 12'hfff);
      send_item(OP_FREE, 13'd0, 12'd0);
      send_item(OP_FREE, 13'd0, 12'd15);
      send_item(OP_FREE, 13'd0, 12'(stray_offset()));
      fa = live_offset();
      send_item(OP_FREE, 13'd0, 12'(fa));
      send_item(OP_FREE, 13'd0, 12'(fa));
      send_item(OP_NONE, 13'h1fff, 12'hfff);
      send_item(OP_QUERY, 13'd0, 12'd0);
      while (live_offset() >= 0) send_item(OP_FREE, 13'd0, 12'(live_offset()));
      send_item(OP_ALLOC, 13'd4064, 12'd0);
      send_item(OP_ALLOC, 13'd0, 12'd0);
      send_item(OP_QUERY, 13'd0, 12'd0);
      send_item(OP_FREE, 13'd0, 12'(live_offset()));
      run_phase(PhaseItems);
      write_magic(32'hFFFF_FFFF);
      hold_request = 1'b1;
      run_phase(PhaseItems);
      safe_bogus = 1'b0;
      write_magic(32'h0000_0000);
      run_phase(PhaseItems);
      safe_bogus = 1'b1;
      write_magic($urandom | 32'h0000_2000);
      steady = 1'b1;
      run_phase(PhaseItems / 2);
      steady = 1'b0;
      run_phase(PhaseItems / 2);
      write_magic(32'h0123_4567);
      run_phase(PhaseItems);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Sent %0d requests over five magic settings; %0d replies checked.",
               items_sent, replies);
      $display("Replies with no fit: %0d, rejected frees: %0d, mismatches: %0d.",
               nofit_seen, badfree_seen, errors);
      if (errors == 0 && pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
